@@ hdl/ilc_pkg.sv @@
// Package for the integer literal converter.
// Holds the word types of both channels, the size class codes and the value limits.
// Depends on nothing.
package ilc_pkg;

   typedef enum logic [1:0] {
      SIZE_INT32  = 2'd0,
      SIZE_UINT32 = 2'd1,
      SIZE_INT64  = 2'd2,
      SIZE_UINT64 = 2'd3
   } size_class_type;

   typedef struct packed {
      logic [7:0] digit_char;
      logic       hex_mode;
      logic       last_digit;
   } req_word_type;

   typedef struct packed {
      logic [63:0]    literal_value;
      size_class_type size_class;
      logic           overflowed;
   } rsp_word_type;

   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;

endpackage

@@ hdl/ilc_accum.sv @@
// Accumulator of the integer literal converter: digit decode, scale and add,
// exact decimal overflow detection and size classification of the finished value.
// Depends on ilc_pkg.
module ilc_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ilc_pkg::req_word_type word,
   output ilc_pkg::rsp_word_type result
);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;

   logic [63:0] accumulator_ff, accumulator_in;
   logic        overflow_ff, overflow_in;
   logic [3:0]  digit;
   logic        is_dec, is_hex_letter;
   logic [63:0] next_value;
   logic        dec_over, next_overflow;

   always_comb begin
      is_dec        = (word.digit_char >= CHAR_ZERO) && (word.digit_char <= CHAR_NINE);
      is_hex_letter = word.hex_mode &&
                      (((word.digit_char >= CHAR_LOW_A) && (word.digit_char <= CHAR_LOW_F)) ||
                       ((word.digit_char >= CHAR_UP_A) && (word.digit_char <= CHAR_UP_F)));
      // Letters a-f and A-F both carry 1..6 in their low nibble.
      if (is_dec) begin
         digit = word.digit_char[3:0];
      end else if (is_hex_letter) begin
         digit = word.digit_char[3:0] + 4'd9;
      end else begin
         digit = 4'd0;
      end

      dec_over = (accumulator_ff > ilc_pkg::DEC_LIMIT) ||
                 ((accumulator_ff == ilc_pkg::DEC_LIMIT) && (digit > 4'd5));

      next_overflow = overflow_ff;
      if (overflow_ff) begin
         next_value = ilc_pkg::ALL_ONES;
      end else if (word.hex_mode) begin
         next_value = {accumulator_ff[59:0], digit};
      end else if (dec_over) begin
         next_value    = ilc_pkg::ALL_ONES;
         next_overflow = 1'b1;
      end else begin
         // Times ten as eight times plus two times.
         next_value = {accumulator_ff[60:0], 3'b000} + {accumulator_ff[62:0], 1'b0}
                      + {60'd0, digit};
      end

      result.literal_value = next_value;
      result.overflowed    = next_overflow;
      if (next_overflow || next_value[63]) begin
         result.size_class = ilc_pkg::SIZE_UINT64;
      end else if (next_value[63:32] != 32'd0) begin
         result.size_class = ilc_pkg::SIZE_INT64;
      end else if (next_value[31]) begin
         result.size_class = ilc_pkg::SIZE_UINT32;
      end else begin
         result.size_class = ilc_pkg::SIZE_INT32;
      end

      accumulator_in = accumulator_ff;
      overflow_in    = overflow_ff;
      if (step) begin
         accumulator_in = word.last_digit ? 64'd0 : next_value;
         overflow_in    = word.last_digit ? 1'b0 : next_overflow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accumulator_ff <= 64'd0;
         overflow_ff    <= 1'b0;
      end else begin
         accumulator_ff <= accumulator_in;
         overflow_ff    <= overflow_in;
      end
   end

endmodule

@@ hdl/ilc_outreg.sv @@
// Result register of the integer literal converter.
// Holds one finished word until the receiver takes it. Depends on ilc_pkg.
module ilc_outreg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ilc_pkg::rsp_word_type load_word,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ilc_pkg::rsp_word_type rsp_word
);

   logic                  valid_ff, valid_in;
   ilc_pkg::rsp_word_type word_ff, word_in;

   always_comb begin
      free     = !valid_ff || !rsp_stall;
      valid_in = load || (valid_ff && rsp_stall);
      word_in  = load ? load_word : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

@@ hdl/integer_literal_converter.sv @@
// Integer literal converter, top level.
// Instantiates ilc_accum and ilc_outreg; uses types and constants from ilc_pkg.
//
// Usage: the req channel carries one ASCII digit character per word, most
// significant digit first, with hex_mode choosing decimal or hexadecimal and
// last_digit marking the final character of the literal. The rsp channel
// carries one word per literal: the 64-bit value, its size class and the
// decimal overflow flag. A word is taken on a rising edge where valid is high
// and stall is low.
// Each accepted character lands in an input register; while it is held there,
// the accumulator scales and adds it in one shift-add step, and a final digit
// loads the result register at the rising edge where it leaves the input
// register, which it does once the result register is free. One character
// is accepted every cycle while no final digit waits on an occupied result
// register; the accumulator update, registered at the edge where the
// character leaves, is what sets that rate.
// When the receiver stalls, the result register holds its word; characters
// that produce no result keep flowing, and the first final digit waits in the
// input register, which then raises req_stall.
// Synchronous reset empties both registers and clears the accumulator and the
// overflow flag, so the next character starts a new literal.
module integer_literal_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ilc_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ilc_pkg::rsp_word_type rsp_word
);

   logic                  in_valid_ff, in_valid_in;
   ilc_pkg::req_word_type in_word_ff, in_word_in;
   logic                  out_free;
   logic                  advance;
   ilc_pkg::rsp_word_type result;

   // The held character moves on unless it finishes a literal and the result
   // register is still occupied by an untaken word.
   always_comb begin
      advance     = in_valid_ff && (!in_word_ff.last_digit || out_free);
      req_stall   = in_valid_ff && !advance;
      in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
      in_word_in  = (req_valid && !req_stall) ? req_word : in_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   ilc_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .word   (in_word_ff),
      .result (result)
   );

   ilc_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && in_word_ff.last_digit),
      .load_word (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // An overflowed literal always reads as saturated and unsigned 64-bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.overflowed |->
         rsp_word.size_class == ilc_pkg::SIZE_UINT64 &&
         rsp_word.literal_value == ilc_pkg::ALL_ONES)
      else $error("overflowed result is not saturated unsigned 64-bit");

   // A signed 32-bit class must really fit in 31 bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.size_class == ilc_pkg::SIZE_INT32 |->
         rsp_word.literal_value[63:31] == 33'd0)
      else $error("int32 class with a value that does not fit");

   // Input is only held off while a final digit waits on a full result register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_word_ff.last_digit && rsp_valid && rsp_stall)
      else $error("input stalled without a blocked final digit");

   // A final digit that is not held off reaches the result register and makes it valid.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_word_ff.last_digit && !req_stall |=> rsp_valid)
      else $error("final digit advanced without producing a result");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for integer_literal_converter.
// Drives literal characters with random gaps and back-pressure and checks every result word
// against an in-bench predictor. Depends on ilc_pkg and the converter RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The predictor keeps its own copies of the limits, so that an error in the
   // package constants cannot hide behind a matching prediction.
   localparam logic [63:0] SATURATED   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] DEC_GUARD   = 64'd1844674407370955161;
   localparam logic [63:0] INT32_MAX   = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] UINT32_MAX  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] INT64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int          CYCLE_LIMIT = 600_000;
   localparam int          HOLD_CYCLES = 400;
   localparam int          REPORT_MAX  = 10;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   ilc_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   ilc_pkg::rsp_word_type rsp_word;

   integer_literal_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Free-running 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: the running value of the literal under way and the
   // sticky decimal overflow flag, both cleared when a literal ends.
   logic [63:0]           value_acc    = '0;
   logic                  dec_overflow = 1'b0;
   ilc_pkg::rsp_word_type literals_due[$];

   // Characters of the literal being assembled before it is sent.
   ilc_pkg::req_word_type literal_chars[$];

   int   chars_sent     = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   int   stall_left     = 0;
   bit   sender_idles   = 1'b1;
   bit   receiver_idles = 1'b1;
   logic hold_off       = 1'b0;
   event hold_start;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // A character that is not a digit of the current base counts as zero, but
   // the accumulator is still scaled for it.
   function automatic logic [63:0] char_digit(logic [7:0] c, logic hex);
      if (c >= "0" && c <= "9")
         return 64'(c - "0");
      if (hex && c >= "a" && c <= "f")
         return 64'(c - "a") + 64'd10;
      if (hex && c >= "A" && c <= "F")
         return 64'(c - "A") + 64'd10;
      return 64'd0;
   endfunction

   function automatic ilc_pkg::size_class_type smallest_size(logic [63:0] v);
      if (v <= INT32_MAX)
         return ilc_pkg::SIZE_INT32;
      if (v <= UINT32_MAX)
         return ilc_pkg::SIZE_UINT32;
      if (v <= INT64_MAX)
         return ilc_pkg::SIZE_INT64;
      return ilc_pkg::SIZE_UINT64;
   endfunction

   // Advances the predicted literal by one accepted character and queues the
   // expected result word when the character closes the literal.
   function automatic void convert_char(ilc_pkg::req_word_type w);
      logic [63:0]           d;
      ilc_pkg::rsp_word_type r;
      d = char_digit(w.digit_char, w.hex_mode);
      if (dec_overflow) begin
         // Once a decimal overflow is seen, nothing more can change the value.
         value_acc = SATURATED;
      end else if (w.hex_mode) begin
         value_acc = (value_acc << 4) + d;
      end else if (value_acc > DEC_GUARD || (value_acc == DEC_GUARD && d > 64'd5)) begin
         dec_overflow = 1'b1;
         value_acc    = SATURATED;
      end else begin
         value_acc = value_acc * 64'd10 + d;
      end
      if (w.last_digit) begin
         r.literal_value = value_acc;
         r.size_class    = dec_overflow ? ilc_pkg::SIZE_UINT64 : smallest_size(value_acc);
         r.overflowed    = dec_overflow;
         literals_due.push_back(r);
         value_acc    = '0;
         dec_overflow = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endfunction

   // Every result word taken by the receiver is compared with the oldest
   // prediction. Sampling happens on the clock edge, before the block's own
   // updates for that edge take effect, so the handshake seen here is the one
   // the block saw.
   always @(posedge clock) begin
      ilc_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (literals_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result: value %0d class %0d overflow %0b",
                                    rsp_word.literal_value, rsp_word.size_class,
                                    rsp_word.overflowed));
         end else begin
            want = literals_due.pop_front();
            if (rsp_word.literal_value !== want.literal_value ||
                rsp_word.size_class !== want.size_class ||
                rsp_word.overflowed !== want.overflowed) begin
               note_mismatch($sformatf(
                  "value exp %0d got %0d, class exp %0d got %0d, overflow exp %0b got %0b",
                  want.literal_value, rsp_word.literal_value, want.size_class,
                  rsp_word.size_class, want.overflowed, rsp_word.overflowed));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: draws a fresh wait for every result it takes, and obeys the
   // long hold-off while one is running. The wait counts down whether or not
   // a result is on offer, so stalls fall on every phase of the block.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         stall_left = receiver_idles ? $urandom_range(0, 15) : 0;
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // The long hold-off is timed here, apart from the sender, so that the
   // sender keeps offering characters while the result side is blocked.
   initial begin
      forever begin
         @(hold_start);
         hold_off <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, literals_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Offers one word after a random gap and holds it until the block takes
   // it. Called just after a rising edge; the only assignments to valid in a
   // step are either the lowering for a gap or the raising for the word.
   task automatic send_char(input ilc_pkg::req_word_type w);
      int gap;
      gap = sender_idles ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      convert_char(w);
      chars_sent++;
   endtask

   function automatic void add_char(logic [7:0] c, logic hex);
      ilc_pkg::req_word_type w;
      w.digit_char = c;
      w.hex_mode   = hex;
      w.last_digit = 1'b0;
      literal_chars.push_back(w);
   endfunction

   // Sends the assembled literal, marking its final character.
   task automatic send_literal();
      ilc_pkg::req_word_type w;
      while (literal_chars.size() > 0) begin
         w = literal_chars.pop_front();
         w.last_digit = (literal_chars.size() == 0);
         send_char(w);
      end
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
      if (n < 4'd10)
         return 8'("0" + n);
      return upper ? 8'("A" + n - 4'd10) : 8'("a" + n - 4'd10);
   endfunction

   // A well-formed digit of the given base, letters in either case.
   function automatic logic [7:0] random_digit(logic hex);
      if (hex)
         return hex_char(4'($urandom_range(0, 15)), bit'($urandom_range(0, 1)));
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic void add_decimal_value(logic [63:0] v);
      logic [7:0] digits[$];
      do begin
         digits.push_front(8'(v % 64'd10) + 8'h30);
         v = v / 64'd10;
      end while (v != 64'd0);
      foreach (digits[i])
         add_char(digits[i], 1'b0);
   endfunction

   // Writes v as ndig hex digits, most significant first (ndig at most 16).
   function automatic void add_hex_value(logic [63:0] v, int ndig);
      for (int i = ndig - 1; i >= 0; i--)
         add_char(hex_char(v[i*4 +: 4], bit'($urandom_range(0, 1))), 1'b1);
   endfunction

   // Values on either side of which the size class changes.
   function automatic logic [63:0] size_edge(int k);
      case (k)
         0:       return INT32_MAX;
         1:       return INT32_MAX + 64'd1;
         2:       return UINT32_MAX;
         3:       return UINT32_MAX + 64'd1;
         4:       return INT64_MAX;
         5:       return INT64_MAX + 64'd1;
         6:       return SATURATED;
         default: return 64'd0;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // The codes 8'h00 in hex and 8'hFF in decimal and the digits 0 and f, all as single-digit
   // literals; the two codes are invalid characters that must count as zero.
   task automatic test_field_extremes();
      add_char("0", 1'b0);
      send_literal();
      add_char(8'hFF, 1'b0);
      send_literal();
      add_char(8'h00, 1'b1);
      send_literal();
      add_char("f", 1'b1);
      send_literal();
   endtask

   // Each character follows its own hex_mode: a hex digit then a decimal one.
   task automatic test_mode_change();
      add_char("A", 1'b1);
      add_char("9", 1'b0);
      send_literal();
   endtask

   // Sixteen hex digits push the value past the decimal guard; the next
   // decimal digit overflows, and neither a hex nor a decimal digit after it
   // may move the value off all ones.
   task automatic test_sticky_overflow();
      add_char("2", 1'b1);
      repeat (15) add_char("0", 1'b1);
      add_char("0", 1'b0);
      add_char("F", 1'b1);
      add_char("1", 1'b0);
      send_literal();
   endtask

   // Random decimal literals: short and long digit strings, values around
   // each size-class edge, values next to the overflow threshold, and
   // saturated literals followed by a tail in either base.
   task automatic test_decimal_literals(int n_chars);
      int goal;
      int kind;
      int len;
      logic hex;
      goal = chars_sent + n_chars;
      while (chars_sent < goal) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4) begin
            len = (kind < 3) ? $urandom_range(1, 10) : $urandom_range(11, 21);
            repeat (len) add_char(random_digit(1'b0), 1'b0);
         end else if (kind <= 7) begin
            add_decimal_value(size_edge($urandom_range(0, 7)) + 64'($urandom_range(0, 4)) - 64'd2);
         end else if (kind == 8) begin
            // One digit either side of the point where times ten plus the
            // digit no longer fits in 64 bits.
            add_decimal_value(DEC_GUARD - 64'd1 + 64'($urandom_range(0, 2)));
            add_char(random_digit(1'b0), 1'b0);
            repeat ($urandom_range(0, 1)) add_char(random_digit(1'b0), 1'b0);
         end else begin
            add_decimal_value(SATURATED);
            repeat ($urandom_range(1, 3)) begin
               hex = logic'($urandom_range(0, 1));
               add_char(random_digit(hex), hex);
            end
         end
         send_literal();
      end
   endtask

   // Random hex literals: digit strings long enough to wrap past 64 bits,
   // size-class edges written in minimal or full width, and literals whose
   // base changes from character to character.
   task automatic test_hex_literals(int n_chars);
      int goal;
      int kind;
      int ndig;
      logic hex;
      logic [63:0] v;
      goal = chars_sent + n_chars;
      while (chars_sent < goal) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            repeat ($urandom_range(1, 20)) add_char(random_digit(1'b1), 1'b1);
         end else if (kind <= 8) begin
            v = size_edge($urandom_range(0, 7)) + 64'($urandom_range(0, 4)) - 64'd2;
            ndig = 1;
            while (ndig < 16 && (v >> (4 * ndig)) != 64'd0)
               ndig++;
            if ($urandom_range(0, 1))
               ndig = 16;
            add_hex_value(v, ndig);
         end else begin
            repeat ($urandom_range(1, 18)) begin
               hex = logic'($urandom_range(0, 1));
               add_char(random_digit(hex), hex);
            end
         end
         send_literal();
      end
   endtask

   // Broken literals: any character code, letters in decimal mode and a
   // base chosen afresh for every character.
   task automatic test_mixed_noise(int n_chars);
      int goal;
      logic hex;
      goal = chars_sent + n_chars;
      while (chars_sent < goal) begin
         repeat ($urandom_range(1, 22)) begin
            hex = logic'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0:       add_char(8'($urandom_range(0, 255)), hex);
               2:       add_char(random_digit(1'b1), hex);
               default: add_char(random_digit(1'b0), hex);
            endcase
         end
         send_literal();
      end
   endtask

   // The receiver blocks for a long stretch while the sender offers short
   // literals back to back, so that a result waits in the result register and the
   // block has to stall the input side.
   task automatic test_back_pressure();
      sender_idles = 1'b0;
      -> hold_start;
      repeat (40) begin
         repeat ($urandom_range(1, 4)) add_char(random_digit(1'b0), 1'b0);
         send_literal();
      end
      sender_idles = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_mode_change();
      test_sticky_overflow();

      // Random phases with idling on both sides, on neither, and on each
      // side alone.
      test_decimal_literals(500);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_hex_literals(450);
      sender_idles   = 1'b1;
      test_mixed_noise(300);
      sender_idles   = 1'b0;
      receiver_idles = 1'b1;
      test_decimal_literals(300);
      test_back_pressure();
      sender_idles   = 1'b1;
      test_hex_literals(200);

      req_valid <= 1'b0;
      while (literals_due.size() != 0) @(posedge clock);
      // Let the pipeline drain so that a stray extra result would be seen.
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
